@@ rtl/cdr_pkg.sv @@
// ----------------------------------------------------------------------------
// cdr_pkg
// Shared types, constants and register codes of the delta regression block.
// ----------------------------------------------------------------------------
`default_nettype none

package cdr_pkg;

  // default sizes
  localparam int MAX_COEFFS = 16;
  localparam int MAX_WINDOW = 3;

  // fixed field widths
  localparam int DATA_W    = 32;
  localparam int WIN_W     = 2;
  localparam int COEFFS_W  = 5;
  localparam int SCALE_W   = 17;
  localparam int FSEEN_W   = 3;
  localparam int CFG_AW    = 4;
  localparam int CFG_DW    = 32;
  localparam int TAP_K_W   = 3;

  // sum of k*x over at most seven taps, |k| <= 3
  localparam int ACC_W     = 36;
  localparam int PROD_W    = ACC_W + SCALE_W + 1;

  localparam logic [FSEEN_W-1:0]  FSEEN_MAX = 3'd7;
  localparam logic [SCALE_W-1:0]  SCALE_MAX = 17'd65536;

  // register reset values
  localparam logic [WIN_W-1:0]    WINDOW_RST = 2'd2;
  localparam logic [COEFFS_W-1:0] COEFFS_RST = 5'd13;
  localparam logic [SCALE_W-1:0]  SCALE_RST  = 17'd10923;

  // register indexes
  typedef enum logic [1:0] {
    REG_WINDOW = 2'd0,
    REG_COEFFS = 2'd1,
    REG_SCALE  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [WIN_W-1:0]    window;
    logic [COEFFS_W-1:0] coeffs;
    logic [SCALE_W-1:0]  scale;    // already limited to SCALE_MAX
  } cfg_regs_t;

  typedef struct packed {
    logic                      clr;
    logic                      acc_en;
    logic signed [TAP_K_W-1:0] tap_k;
    logic                      mul_en;
  } mac_ctrl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRITE,
    S_TAP,
    S_MUL,
    S_SAT,
    S_PRD,
    S_PDAT,
    S_EMIT,
    S_ZERO,
    S_FRD,
    S_FDAT,
    S_FINISH
  } seq_state_t;

endpackage

`default_nettype wire

@@ rtl/cdr_in_if.sv @@
// ----------------------------------------------------------------------------
// cdr_in_if
// Input channel: one coefficient item per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdr_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [cdr_pkg::DATA_W-1:0] coeff_value;
  logic                              last_item;

  modport source (output valid, output coeff_value, output last_item, input ready);
  modport sink   (input valid, input coeff_value, input last_item, output ready);
endinterface

`default_nettype wire

@@ rtl/cdr_out_if.sv @@
// ----------------------------------------------------------------------------
// cdr_out_if
// Result channel: one delta or passed-through coefficient per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdr_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [cdr_pkg::DATA_W-1:0] delta_value;
  logic                              is_last;

  modport source (output valid, output delta_value, output is_last, input ready);
  modport sink   (input valid, input delta_value, input is_last, output ready);
endinterface

`default_nettype wire

@@ rtl/cdr_ram.sv @@
// ----------------------------------------------------------------------------
// cdr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module cdr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/cdr_cfg.sv @@
// ----------------------------------------------------------------------------
// cdr_cfg
// APB-style register file: window, coefficients per frame, reciprocal scale.
// ----------------------------------------------------------------------------
`default_nettype none

module cdr_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [cdr_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [cdr_pkg::CFG_DW-1:0]   pwdata,
  output logic      [cdr_pkg::CFG_DW-1:0]   prdata,
  output logic                              pready,
  output cdr_pkg::cfg_regs_t                cfg
);

  logic [cdr_pkg::WIN_W-1:0]    window_r;
  logic [cdr_pkg::COEFFS_W-1:0] coeffs_r;
  logic [cdr_pkg::SCALE_W-1:0]  scale_r;
  logic [1:0]                   reg_idx;
  logic                         wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= cdr_pkg::WINDOW_RST;
      coeffs_r <= cdr_pkg::COEFFS_RST;
      scale_r  <= cdr_pkg::SCALE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        cdr_pkg::REG_WINDOW: window_r <= pwdata[cdr_pkg::WIN_W-1:0];
        cdr_pkg::REG_COEFFS: coeffs_r <= pwdata[cdr_pkg::COEFFS_W-1:0];
        cdr_pkg::REG_SCALE:  scale_r  <= pwdata[cdr_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      cdr_pkg::REG_WINDOW: prdata = cdr_pkg::CFG_DW'(window_r);
      cdr_pkg::REG_COEFFS: prdata = cdr_pkg::CFG_DW'(coeffs_r);
      cdr_pkg::REG_SCALE:  prdata = cdr_pkg::CFG_DW'(scale_r);
      default:             prdata = '0;
    endcase
  end

  assign cfg.window = window_r;
  assign cfg.coeffs = coeffs_r;
  assign cfg.scale  = (scale_r > cdr_pkg::SCALE_MAX) ? cdr_pkg::SCALE_MAX : scale_r;

endmodule

`default_nettype wire

@@ rtl/cdr_mac.sv @@
// ----------------------------------------------------------------------------
// cdr_mac
// Shared arithmetic unit: tap accumulate, scale multiply, shift and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module cdr_mac (
  input  wire logic                              clk,
  input  wire cdr_pkg::mac_ctrl_t                ctrl,
  input  wire logic signed [cdr_pkg::DATA_W-1:0] x,
  input  wire logic [cdr_pkg::SCALE_W-1:0]       scale,
  output logic signed [cdr_pkg::DATA_W-1:0]      result
);

  localparam int TERM_W = cdr_pkg::DATA_W + cdr_pkg::TAP_K_W;
  localparam int Q_W    = cdr_pkg::PROD_W - 16;

  logic signed [cdr_pkg::ACC_W-1:0]  acc_r;
  logic signed [cdr_pkg::PROD_W-1:0] prod_r;
  logic signed [TERM_W-1:0]          term;
  logic signed [Q_W-1:0]             q;

  assign term = x * ctrl.tap_k;

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      acc_r <= '0;
    end else if (ctrl.acc_en) begin
      acc_r <= acc_r + cdr_pkg::ACC_W'(term);
    end
    if (ctrl.mul_en) begin
      prod_r <= acc_r * $signed({1'b0, scale});
    end
  end

  // floor shift, then clamp to signed 32 bits
  assign q = $signed(prod_r[cdr_pkg::PROD_W-1:16]);

  always_comb begin
    if (q[Q_W-1:cdr_pkg::DATA_W-1] == '0 || q[Q_W-1:cdr_pkg::DATA_W-1] == '1) begin
      result = q[cdr_pkg::DATA_W-1:0];
    end else if (q[Q_W-1]) begin
      result = {1'b1, {(cdr_pkg::DATA_W-1){1'b0}}};
    end else begin
      result = {1'b0, {(cdr_pkg::DATA_W-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

@@ rtl/cdr_seq.sv @@
// ----------------------------------------------------------------------------
// cdr_seq
// Sequencer: frame ring addressing, tap walk, flush, and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cdr_seq #(
  parameter int MAX_COEFFS = cdr_pkg::MAX_COEFFS,
  parameter int MAX_WINDOW = cdr_pkg::MAX_WINDOW
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire cdr_pkg::cfg_regs_t        cfg,
  cdr_in_if.sink                         in_ch,
  cdr_out_if.source                      out_ch,
  output logic                           ram_we,
  output logic [$clog2((2*MAX_WINDOW+1)*MAX_COEFFS)-1:0] ram_waddr,
  output logic [cdr_pkg::DATA_W-1:0]     ram_wdata,
  output logic [$clog2((2*MAX_WINDOW+1)*MAX_COEFFS)-1:0] ram_raddr,
  input  wire logic [cdr_pkg::DATA_W-1:0] ram_rdata,
  output cdr_pkg::mac_ctrl_t             mac_ctrl,
  input  wire logic signed [cdr_pkg::DATA_W-1:0] mac_result
);

  localparam int RING_FRAMES = 2 * MAX_WINDOW + 1;
  localparam int SPAN_W      = $clog2(RING_FRAMES + 1);
  localparam int IDX_W       = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;
  localparam int CNT_W       = $clog2(MAX_COEFFS + 1);
  localparam int ADDR_W      = $clog2(RING_FRAMES * MAX_COEFFS);
  localparam int DW          = cdr_pkg::DATA_W;
  localparam int KW          = cdr_pkg::TAP_K_W;

  cdr_pkg::seq_state_t state_r, state_nxt;

  logic [IDX_W-1:0]             coeff_index_r, coeff_index_nxt;
  logic [SPAN_W-1:0]            write_slot_r, write_slot_nxt;
  logic [cdr_pkg::FSEEN_W-1:0]  frames_seen_r, frames_seen_nxt;
  logic [SPAN_W-1:0]            cnt_r, cnt_nxt;
  logic [CNT_W-1:0]             idx_r, idx_nxt;
  logic                         tap_vld_r, tap_vld_nxt;
  logic signed [KW-1:0]         tap_k_r, tap_k_nxt;
  logic                         flush_r, flush_nxt;
  logic                         out_valid_r, out_valid_nxt;

  logic [DW-1:0]                val_r, val_nxt;
  logic                         last_r, last_nxt;
  logic [DW-1:0]                res_r, res_nxt;
  logic                         res_last_r, res_last_nxt;
  logic [DW-1:0]                out_data_r, out_data_nxt;
  logic                         out_last_r, out_last_nxt;

  logic [cdr_pkg::WIN_W-1:0]    win;
  logic [CNT_W-1:0]             ncoef;
  logic [SPAN_W-1:0]            span;
  logic [SPAN_W-1:0]            ws;
  logic [SPAN_W-1:0]            ws_inc;
  logic [CNT_W-1:0]             j_plus;
  logic                         frame_end;
  logic                         has_main;
  logic                         is_delta;
  logic [SPAN_W-1:0]            first_back;
  logic                         issuing;
  logic signed [SPAN_W+1:0]     k_wide;
  logic                         out_free;

  function automatic logic [SPAN_W-1:0] wrap_slot(input logic [SPAN_W-1:0] s,
                                                  input logic [SPAN_W-1:0] sp);
    logic [SPAN_W-1:0] r;
    r = s;
    if (r >= sp) r = r - sp;
    if (r >= sp) r = r - sp;
    return r;
  endfunction

  // ring slot that lies "back" frames behind the current write slot
  function automatic logic [SPAN_W-1:0] slot_of(input logic [SPAN_W-1:0] cur,
                                                input logic [SPAN_W-1:0] back,
                                                input logic [SPAN_W-1:0] sp);
    logic [SPAN_W-1:0] r;
    r = cur - back;
    if (cur < back) r = cur + sp - back;
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [SPAN_W-1:0] slot,
                                                input logic [IDX_W-1:0] idx);
    return ADDR_W'(slot * MAX_COEFFS + idx);
  endfunction

  // register values limited to the supported ranges
  always_comb begin
    if (cfg.window == '0) begin
      win = cdr_pkg::WIN_W'(1);
    end else if (int'(cfg.window) > MAX_WINDOW) begin
      win = cdr_pkg::WIN_W'(MAX_WINDOW);
    end else begin
      win = cfg.window;
    end
    if (cfg.coeffs == '0) begin
      ncoef = CNT_W'(1);
    end else if (int'(cfg.coeffs) > MAX_COEFFS) begin
      ncoef = CNT_W'(MAX_COEFFS);
    end else begin
      ncoef = CNT_W'(cfg.coeffs);
    end
  end

  assign span       = SPAN_W'({win, 1'b1});
  assign ws         = wrap_slot(write_slot_r, span);
  assign ws_inc     = (ws + SPAN_W'(1) == span) ? '0 : ws + SPAN_W'(1);
  assign j_plus     = CNT_W'(coeff_index_r) + CNT_W'(1);
  assign frame_end  = j_plus >= ncoef;
  assign has_main   = frames_seen_r >= {1'b0, win};
  assign is_delta   = frames_seen_r >= {win, 1'b0};
  assign first_back = has_main ? SPAN_W'(win - cdr_pkg::WIN_W'(1)) : SPAN_W'(frames_seen_r);
  assign issuing    = cnt_r < span;
  assign k_wide     = $signed({2'b00, SPAN_W'(win)}) - $signed({2'b00, cnt_r});
  assign out_free   = !out_valid_r || out_ch.ready;

  assign in_ch.ready        = (state_r == cdr_pkg::S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.delta_value = out_data_r;
  assign out_ch.is_last     = out_last_r;

  always_comb begin
    state_nxt       = state_r;
    coeff_index_nxt = coeff_index_r;
    write_slot_nxt  = write_slot_r;
    frames_seen_nxt = frames_seen_r;
    cnt_nxt         = cnt_r;
    idx_nxt         = idx_r;
    tap_vld_nxt     = 1'b0;
    tap_k_nxt       = tap_k_r;
    flush_nxt       = flush_r;
    out_valid_nxt   = out_ch.ready ? 1'b0 : out_valid_r;
    val_nxt         = val_r;
    last_nxt        = last_r;
    res_nxt         = res_r;
    res_last_nxt    = res_last_r;
    out_data_nxt    = out_data_r;
    out_last_nxt    = out_last_r;
    ram_we          = 1'b0;
    ram_waddr       = addr_of(ws, coeff_index_r);
    ram_wdata       = val_r;
    ram_raddr       = '0;
    mac_ctrl        = '0;

    case (state_r)
      cdr_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          val_nxt   = in_ch.coeff_value;
          last_nxt  = in_ch.last_item;
          flush_nxt = 1'b0;
          state_nxt = cdr_pkg::S_WRITE;
        end
      end

      cdr_pkg::S_WRITE: begin
        ram_we = 1'b1;
        if (has_main && is_delta) begin
          cnt_nxt      = '0;
          mac_ctrl.clr = 1'b1;
          state_nxt    = cdr_pkg::S_TAP;
        end else if (has_main) begin
          state_nxt = cdr_pkg::S_PRD;
        end else if (last_r) begin
          idx_nxt   = j_plus;
          state_nxt = cdr_pkg::S_ZERO;
        end else begin
          state_nxt = cdr_pkg::S_FINISH;
        end
      end

      // read one tap a cycle, accumulate the previous read
      cdr_pkg::S_TAP: begin
        mac_ctrl.acc_en = tap_vld_r;
        mac_ctrl.tap_k  = tap_k_r;
        if (issuing) begin
          ram_raddr   = addr_of(slot_of(ws, cnt_r, span), coeff_index_r);
          cnt_nxt     = cnt_r + SPAN_W'(1);
          tap_vld_nxt = 1'b1;
          tap_k_nxt   = k_wide[KW-1:0];
        end else if (tap_vld_r) begin
          state_nxt = cdr_pkg::S_MUL;
        end
      end

      cdr_pkg::S_MUL: begin
        mac_ctrl.mul_en = 1'b1;
        state_nxt       = cdr_pkg::S_SAT;
      end

      cdr_pkg::S_SAT: begin
        res_nxt      = mac_result;
        res_last_nxt = 1'b0;
        state_nxt    = cdr_pkg::S_EMIT;
      end

      cdr_pkg::S_PRD: begin
        ram_raddr = addr_of(slot_of(ws, SPAN_W'(win), span), coeff_index_r);
        state_nxt = cdr_pkg::S_PDAT;
      end

      cdr_pkg::S_PDAT: begin
        res_nxt      = ram_rdata;
        res_last_nxt = 1'b0;
        state_nxt    = cdr_pkg::S_EMIT;
      end

      cdr_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          out_last_nxt  = res_last_r;
          if (flush_r) begin
            if (res_last_r) begin
              state_nxt = cdr_pkg::S_FINISH;
            end else begin
              if (idx_r + CNT_W'(1) == ncoef) begin
                idx_nxt = '0;
                cnt_nxt = cnt_r - SPAN_W'(1);
              end else begin
                idx_nxt = idx_r + CNT_W'(1);
              end
              state_nxt = cdr_pkg::S_FRD;
            end
          end else if (last_r) begin
            idx_nxt   = j_plus;
            state_nxt = cdr_pkg::S_ZERO;
          end else begin
            state_nxt = cdr_pkg::S_FINISH;
          end
        end
      end

      // clear the missing tail of a frame cut short by the last item
      cdr_pkg::S_ZERO: begin
        if (idx_r < ncoef) begin
          ram_we    = 1'b1;
          ram_waddr = addr_of(ws, idx_r[IDX_W-1:0]);
          ram_wdata = '0;
          idx_nxt   = idx_r + CNT_W'(1);
        end else begin
          cnt_nxt   = first_back;
          idx_nxt   = '0;
          flush_nxt = 1'b1;
          state_nxt = cdr_pkg::S_FRD;
        end
      end

      cdr_pkg::S_FRD: begin
        ram_raddr = addr_of(slot_of(ws, cnt_r, span), idx_r[IDX_W-1:0]);
        state_nxt = cdr_pkg::S_FDAT;
      end

      cdr_pkg::S_FDAT: begin
        res_nxt      = ram_rdata;
        res_last_nxt = (cnt_r == '0) && (idx_r + CNT_W'(1) == ncoef);
        state_nxt    = cdr_pkg::S_EMIT;
      end

      cdr_pkg::S_FINISH: begin
        if (last_r) begin
          coeff_index_nxt = '0;
          write_slot_nxt  = '0;
          frames_seen_nxt = '0;
        end else if (frame_end) begin
          coeff_index_nxt = '0;
          write_slot_nxt  = ws_inc;
          if (frames_seen_r != cdr_pkg::FSEEN_MAX) begin
            frames_seen_nxt = frames_seen_r + cdr_pkg::FSEEN_W'(1);
          end
        end else begin
          coeff_index_nxt = j_plus[IDX_W-1:0];
          write_slot_nxt  = ws;
        end
        flush_nxt = 1'b0;
        state_nxt = cdr_pkg::S_IDLE;
      end

      default: begin
        state_nxt = cdr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cdr_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_index_r <= '0;
      write_slot_r  <= '0;
      frames_seen_r <= '0;
      cnt_r         <= '0;
      idx_r         <= '0;
      tap_vld_r     <= 1'b0;
      tap_k_r       <= '0;
      flush_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      coeff_index_r <= coeff_index_nxt;
      write_slot_r  <= write_slot_nxt;
      frames_seen_r <= frames_seen_nxt;
      cnt_r         <= cnt_nxt;
      idx_r         <= idx_nxt;
      tap_vld_r     <= tap_vld_nxt;
      tap_k_r       <= tap_k_nxt;
      flush_r       <= flush_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    last_r     <= last_nxt;
    res_r      <= res_nxt;
    res_last_r <= res_last_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/cepstral_delta_regression_top.sv @@
// ----------------------------------------------------------------------------
// cepstral_delta_regression_top
// Delta regression over a ring of 2W+1 feature frames, one coefficient a item.
// ----------------------------------------------------------------------------
// Delta result: item written, taps walked through the single ring read port, multiplied,
//   saturated and registered; a new item is taken only once the last one is done.
// Pass-through result: read back from the ring; an item without result returns to idle.
// Last item: the frame tail is cleared, then buffered frames are flushed one by one.
// Reset: synchronous, active low; clears sequence state, the output valid flag
//   and the registers; ring contents stay undefined and need no clearing pass.
`default_nettype none

module cepstral_delta_regression_top #(
  parameter int MAX_COEFFS = cdr_pkg::MAX_COEFFS,
  parameter int MAX_WINDOW = cdr_pkg::MAX_WINDOW
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  cdr_in_if.sink                          in_ch,
  cdr_out_if.source                       out_ch,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [cdr_pkg::CFG_AW-1:0] paddr,
  input  wire logic [cdr_pkg::CFG_DW-1:0] pwdata,
  output logic      [cdr_pkg::CFG_DW-1:0] prdata,
  output logic                            pready
);

  localparam int DEPTH  = (2 * MAX_WINDOW + 1) * MAX_COEFFS;
  localparam int ADDR_W = $clog2(DEPTH);

  cdr_pkg::cfg_regs_t                 cfg;
  cdr_pkg::mac_ctrl_t                 mac_ctrl;
  logic signed [cdr_pkg::DATA_W-1:0]  mac_result;
  logic                               ram_we;
  logic [ADDR_W-1:0]                  ram_waddr;
  logic [ADDR_W-1:0]                  ram_raddr;
  logic [cdr_pkg::DATA_W-1:0]         ram_wdata;
  logic [cdr_pkg::DATA_W-1:0]         ram_rdata;

  cdr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cdr_ram #(
    .WIDTH (cdr_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cdr_mac u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .x      ($signed(ram_rdata)),
    .scale  (cfg.scale),
    .result (mac_result)
  );

  cdr_seq #(
    .MAX_COEFFS (MAX_COEFFS),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .mac_ctrl   (mac_ctrl),
    .mac_result (mac_result)
  );

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives coefficient items into the delta regression block, predicts every
// delta and passed-through value from a local copy of the frame history, and
// checks each result in order. Configuration changes happen between sequences.
// ----------------------------------------------------------------------------

module tb;

  localparam int RING_FRAMES   = 2 * cdr_pkg::MAX_WINDOW + 1;
  localparam int SETTLE_CYCLES = 40;
  localparam int WATCHDOG      = 2000;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 94;

  typedef struct {
    logic [cdr_pkg::DATA_W-1:0] value;
    logic                       last;
  } coeff_item_t;

  typedef struct packed {
    logic signed [cdr_pkg::DATA_W-1:0] value;
    logic                              last;
  } delta_t;

  logic clk;
  logic rst_n;

  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [cdr_pkg::CFG_AW-1:0] paddr;
  logic [cdr_pkg::CFG_DW-1:0] pwdata;
  logic [cdr_pkg::CFG_DW-1:0] prdata;
  logic                       pready;

  cdr_in_if  in_ch ();
  cdr_out_if out_ch ();

  cepstral_delta_regression_top uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  logic [cdr_pkg::DATA_W-1:0]   frame_hist [RING_FRAMES][cdr_pkg::MAX_COEFFS];
  int unsigned                  cur_coeff;
  int unsigned                  cur_slot;
  int unsigned                  frames_done;
  logic [cdr_pkg::WIN_W-1:0]    reg_window;
  logic [cdr_pkg::COEFFS_W-1:0] reg_coeffs;
  logic [cdr_pkg::SCALE_W-1:0]  reg_scale;

  coeff_item_t coeff_q [$];
  delta_t      delta_q [$];

  int unsigned items_sent;
  int unsigned items_acc;
  int unsigned err_cnt;
  int unsigned idle_cyc;
  logic        in_taken;
  int unsigned tx_gap;
  bit          tx_calm;
  int unsigned rx_gap;
  bit          rx_calm;
  int unsigned hold_left;
  bit          hold_done;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [cdr_pkg::DATA_W-1:0] ring_at(int unsigned ws, span, back, j);
    return frame_hist[(ws + span - back) % span][j % cdr_pkg::MAX_COEFFS];
  endfunction

  // sum of k*x over the window, scaled in Q16, floored and saturated
  function automatic logic [cdr_pkg::DATA_W-1:0] regress(int unsigned ws, span, w, j);
    longint acc;
    longint prod;
    longint q;
    int     k;
    acc = 0;
    for (k = -int'(w); k <= int'(w); k++)
      acc += longint'(k) * longint'($signed(ring_at(ws, span, int'(w) - k, j)));
    prod = acc * ((reg_scale > cdr_pkg::SCALE_MAX) ? longint'(cdr_pkg::SCALE_MAX)
                                                   : longint'(reg_scale));
    q = prod >>> 16;
    if (q > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (q < -64'sd2147483648) return 32'h8000_0000;
    return q[cdr_pkg::DATA_W-1:0];
  endfunction

  task automatic predict_deltas(logic [cdr_pkg::DATA_W-1:0] x, logic last);
    int unsigned w;
    int unsigned c;
    int unsigned span;
    int unsigned ws;
    int unsigned j;
    int unsigned f;
    int unsigned fb;
    int unsigned idx;
    int          b;
    w = (reg_window == 0) ? 1 : reg_window;
    c = (reg_coeffs == 0) ? 1 :
        ((reg_coeffs > cdr_pkg::MAX_COEFFS) ? cdr_pkg::MAX_COEFFS : reg_coeffs);
    span = 2 * w + 1;
    ws = cur_slot % span;
    j = cur_coeff % cdr_pkg::MAX_COEFFS;
    f = frames_done;
    frame_hist[ws][j] = x;
    if (f >= w)
      delta_q.push_back({(f >= 2 * w) ? regress(ws, span, w, j) : ring_at(ws, span, w, j),
                         1'b0});
    if (last) begin
      // missing coefficients of a short final frame read as zero
      for (idx = j + 1; idx < c; idx++)
        frame_hist[ws][idx] = '0;
      fb = (f >= w) ? w - 1 : f;
      for (b = int'(fb); b >= 0; b--) begin
        for (idx = 0; idx < c; idx++)
          delta_q.push_back({ring_at(ws, span, b, idx), 1'b0});
      end
      delta_q[delta_q.size() - 1].last = 1'b1;
      cur_coeff = 0;
      cur_slot = 0;
      frames_done = 0;
    end else if (j + 1 >= c) begin
      cur_coeff = 0;
      cur_slot = (ws + 1) % span;
      if (frames_done < cdr_pkg::FSEEN_MAX) frames_done++;
    end else begin
      cur_coeff = j + 1;
      cur_slot = ws;
    end
  endtask

  // sender
  always @(negedge clk) begin
    coeff_item_t nxt;
    if ($urandom_range(0, 149) == 0) tx_calm <= !tx_calm;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
      // item still on offer
    end else if (tx_gap > 0) begin
      in_ch.valid <= 1'b0;
      tx_gap <= tx_gap - 1;
    end else if (coeff_q.size() != 0) begin
      nxt = coeff_q.pop_front();
      in_ch.valid <= 1'b1;
      in_ch.coeff_value <= nxt.value;
      in_ch.last_item <= nxt.last;
      tx_gap <= pick_gap(tx_calm);
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // receiver, with one long hold-off while the sender keeps offering
  always @(negedge clk) begin
    if ($urandom_range(0, 149) == 0) rx_calm <= !rx_calm;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && in_ch.valid && items_acc >= 120) begin
      out_ch.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (rx_gap > 0) begin
      out_ch.ready <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else begin
      out_ch.ready <= 1'b1;
      rx_gap <= pick_gap(rx_calm);
    end
  end

  // monitor: check results first, then predict from the accepted item
  always @(posedge clk) begin
    delta_t want;
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (delta_q.size() == 0) begin
          $error("unexpected result: delta_value %0d is_last %0b",
                 out_ch.delta_value, out_ch.is_last);
          err_cnt++;
        end else begin
          want = delta_q.pop_front();
          if (out_ch.delta_value !== want.value) begin
            $error("delta_value: expected %0d, got %0d", want.value, out_ch.delta_value);
            err_cnt++;
          end
          if (out_ch.is_last !== want.last) begin
            $error("is_last: expected %0b, got %0b", want.last, out_ch.is_last);
            err_cnt++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_deltas(in_ch.coeff_value, in_ch.last_item);
        items_acc++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || psel || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= WATCHDOG) begin
      $display("tb: errors");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  task automatic cfg_write(cdr_pkg::reg_idx_t idx, logic [cdr_pkg::CFG_DW-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      cdr_pkg::REG_WINDOW: reg_window = value[cdr_pkg::WIN_W-1:0];
      cdr_pkg::REG_COEFFS: reg_coeffs = value[cdr_pkg::COEFFS_W-1:0];
      cdr_pkg::REG_SCALE:  reg_scale  = value[cdr_pkg::SCALE_W-1:0];
      default: ;
    endcase
  endtask

  // wait for every item to be taken and every result to come back
  task automatic drain();
    do @(negedge clk); while (items_acc != items_sent || delta_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(logic [cdr_pkg::WIN_W-1:0] w, logic [cdr_pkg::COEFFS_W-1:0] c,
                            logic [cdr_pkg::SCALE_W-1:0] s);
    drain();
    cfg_write(cdr_pkg::REG_WINDOW, cdr_pkg::CFG_DW'(w));
    cfg_write(cdr_pkg::REG_COEFFS, cdr_pkg::CFG_DW'(c));
    cfg_write(cdr_pkg::REG_SCALE, cdr_pkg::CFG_DW'(s));
  endtask

  task automatic push_item(logic [cdr_pkg::DATA_W-1:0] value, logic last);
    coeff_q.push_back('{value: value, last: last});
    items_sent++;
  endtask

  function automatic logic [cdr_pkg::DATA_W-1:0] pick_value(int unsigned vmode);
    int unsigned r;
    if (vmode == 0) return $urandom();
    if (vmode == 1) return cdr_pkg::DATA_W'($urandom_range(0, 2097152) - 32'd1048576);
    r = $urandom_range(0, 3);
    if (r == 0) return 32'h7FFF_FFFF;
    if (r == 1) return 32'h8000_0000;
    if (r == 2) return '0;
    return 32'hFFFF_FFFF;
  endfunction

  task automatic queue_sequence(int unsigned n, int unsigned vmode);
    int unsigned i;
    for (i = 0; i < n; i++)
      push_item(pick_value(vmode), i == n - 1);
  endtask

  // sequences stop at the item budget; the one that meets it is cut short
  task automatic random_phase(logic [cdr_pkg::WIN_W-1:0] w,
                              logic [cdr_pkg::COEFFS_W-1:0] c,
                              logic [cdr_pkg::SCALE_W-1:0] s, int unsigned n_seq,
                              int unsigned limit);
    int unsigned ew;
    int unsigned ec;
    int unsigned frames;
    int unsigned n;
    int unsigned r;
    int unsigned i;
    set_config(w, c, s);
    ew = (w == 0) ? 1 : w;
    ec = (c == 0) ? 1 : ((c > cdr_pkg::MAX_COEFFS) ? cdr_pkg::MAX_COEFFS : c);
    for (i = 0; i < n_seq && items_sent < limit; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        // long enough to reach the regression
        n = (2 * ew + 1 + $urandom_range(0, 3)) * ec;
      end else if (r < 85) begin
        // ends in mid-frame when a frame holds more than one coefficient
        frames = $urandom_range(1, 2 * ew + 2);
        n = frames * ec;
        if (ec > 1) n -= $urandom_range(1, ec - 1);
      end else begin
        n = $urandom_range(1, ew) * ec;
      end
      if (n > limit - items_sent) n = limit - items_sent;
      queue_sequence(n, $urandom_range(0, 2));
    end
  endtask

  initial begin
    int unsigned r;
    int unsigned target;
    logic [cdr_pkg::COEFFS_W-1:0] c;
    logic [cdr_pkg::SCALE_W-1:0]  s;

    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.coeff_value = '0;
    in_ch.last_item = 1'b0;
    out_ch.ready = 1'b0;
    for (int f = 0; f < RING_FRAMES; f++)
      for (int j = 0; j < cdr_pkg::MAX_COEFFS; j++)
        frame_hist[f][j] = '0;
    cur_coeff = 0;
    cur_slot = 0;
    frames_done = 0;
    reg_window = cdr_pkg::WINDOW_RST;
    reg_coeffs = cdr_pkg::COEFFS_RST;
    reg_scale = cdr_pkg::SCALE_RST;
    items_sent = 0;
    items_acc = 0;
    err_cnt = 0;
    idle_cyc = 0;
    in_taken = 1'b0;
    tx_gap = 0;
    tx_calm = 1'b0;
    rx_gap = 0;
    rx_calm = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // narrow window, full scale: saturation both ways
    set_config(2'd1, 5'd2, 17'd65536);
    push_item(32'h7FFF_FFFF, 1'b0);
    push_item(32'h8000_0000, 1'b0);
    push_item(32'h0000_0000, 1'b0);
    push_item(32'hFFFF_FFFF, 1'b0);
    push_item(32'h8000_0000, 1'b0);
    push_item(32'h7FFF_FFFF, 1'b0);
    push_item(32'h0000_0001, 1'b0);
    push_item(32'hFFFF_FFFF, 1'b1);
    // last item in mid-frame
    push_item(32'h0001_0000, 1'b0);
    push_item(32'hFFFF_0000, 1'b0);
    push_item(32'h0003_0000, 1'b1);
    // one item alone
    push_item(32'hFFFF_FFFF, 1'b1);

    // widest window, zero scale, and a sequence shorter than the window
    set_config(2'd3, 5'd1, 17'd0);
    queue_sequence(8, 0);
    queue_sequence(2, 2);

    // largest frame with the widest window: the biggest flush
    set_config(2'd3, 5'd16, 17'd65536);
    queue_sequence(64, 0);

    target = items_sent + RANDOM_ITEMS;
    random_phase(2'd1, 5'd1, 17'd65536, 3, target);
    // out-of-range settings fold into the legal ones
    random_phase(2'd0, 5'd31, 17'd131071, 2, target);
    while (items_sent < target) begin
      r = $urandom_range(0, 99);
      c = (r < 80) ? cdr_pkg::COEFFS_W'($urandom_range(1, 4))
                   : cdr_pkg::COEFFS_W'($urandom_range(5, 16));
      r = $urandom_range(0, 99);
      if (r < 20) s = 17'd65536;
      else if (r < 30) s = 17'd0;
      else s = cdr_pkg::SCALE_W'($urandom_range(0, 65536));
      random_phase(cdr_pkg::WIN_W'($urandom_range(1, 3)), c, s, $urandom_range(1, 3),
                   target);
    end

    drain();
    if (err_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
